// ----- rtl/core/three_source_velocity_fusion_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the three source velocity fusion core
// Concurrent check wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef THREE_SOURCE_VELOCITY_FUSION_CORE_MACROS_SVH
`define THREE_SOURCE_VELOCITY_FUSION_CORE_MACROS_SVH

// checked only outside reset
`define TSVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked through reset as well
`define TSVF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/tsvf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsvf_pkg
// Shared types, command codes, register codes and saturation helpers.
// ----------------------------------------------------------------------------
package tsvf_pkg;

    // datapath commands
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_EMAG = 4'd2;
    localparam logic [3:0] OP_EHI  = 4'd3;
    localparam logic [3:0] OP_ELO  = 4'd4;
    localparam logic [3:0] OP_IMU  = 4'd5;
    localparam logic [3:0] OP_RNG  = 4'd6;
    localparam logic [3:0] OP_SATR = 4'd7;
    localparam logic [3:0] OP_CMP  = 4'd8;
    localparam logic [3:0] OP_FIN  = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd1;
    localparam logic [1:0] CFG_WHEEL_RADIUS  = 2'd2;

    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
    localparam logic [15:0] SAMPLE_RATE_RST   = 16'd100;
    localparam logic [19:0] WHEEL_RADIUS_RST  = 20'd7864;

    localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;
    localparam logic [52:0] MAG_NEG_LIM = 53'h0_0000_8000_0000;
    localparam logic [52:0] MAG_POS_LIM = 53'h0_0000_7FFF_FFFF;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    // sign-magnitude to saturated signed 32
    function automatic logic [31:0] sat_mag(input logic [52:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (mag > MAG_NEG_LIM) begin
                res = S32_MIN;
            end else begin
                res = ~mag[31:0] + 32'd1;
            end
        end else begin
            if (mag > MAG_POS_LIM) begin
                res = S32_MAX;
            end else begin
                res = mag[31:0];
            end
        end
        return res;
    endfunction

    // signed 34 to saturated signed 32
    function automatic logic [31:0] sat_s34(input logic [33:0] v);
        logic [31:0] res;
        if (!v[33] && (v[32:31] != 2'b00)) begin
            res = S32_MAX;
        end else if (v[33] && (v[32:31] != 2'b11)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/three_source_velocity_fusion_core.sv -----
// ----------------------------------------------------------------------------
// three_source_velocity_fusion_core
// Encoder, integrated-acceleration and range speed estimates with a
// closest-pair average, one result per sample.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata[95:0]: wheel_angle, accel_sample, range_distance
//  m_*      | out       | tdata[127:0]: speed_encoder, speed_imu, speed_range, speed_fused
//  cfg_*    | in        | cfg_index[1:0], cfg_data[19:0]
//
//  Each item steps through accept, five passes through the single shared
//  33x20 multiplier, range saturation, pair vote and result load.
//  The result register is loaded in the last step; a held result
//  stalls that final load, and the next item waits until it is done.
//  Reset (aresetn low, synchronous) zeroes history and restores config.
// ----------------------------------------------------------------------------
`include "three_source_velocity_fusion_core_macros.svh"

module three_source_velocity_fusion_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // wheel_angle, accel_sample, range_distance
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // speed_encoder, speed_imu, speed_range, speed_fused
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    tsvf_pkg::dp_cmd_t cmd;
    tsvf_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    tsvf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tsvf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    `TSVF_ASSERT(a_load_on_accept, (cmd.op == tsvf_pkg::OP_LOAD) |-> (s_tvalid && s_tready), "load without accept")
    `TSVF_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> ((cmd.op == tsvf_pkg::OP_EMAG) && !s_tready), "item did not start")
    `TSVF_ASSERT(a_fin_sets_valid, (cmd.op == tsvf_pkg::OP_FIN) |=> m_tvalid, "result not presented")
    `TSVF_ASSERT_RST(a_reset_clears, !aresetn |=> (!m_tvalid && s_tready), "reset did not clear")

endmodule

// ----- rtl/core/tsvf_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsvf_ctrl
// Sequencer: walks one item through the shared-multiplier datapath.
// ----------------------------------------------------------------------------
module tsvf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output tsvf_pkg::dp_cmd_t cmd,
    input  tsvf_pkg::dp_sts_t sts
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EMAG = 4'd1;
    localparam logic [3:0] ST_EHI  = 4'd2;
    localparam logic [3:0] ST_ELO  = 4'd3;
    localparam logic [3:0] ST_IMU  = 4'd4;
    localparam logic [3:0] ST_RNG  = 4'd5;
    localparam logic [3:0] ST_SATR = 4'd6;
    localparam logic [3:0] ST_CMP  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = tsvf_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = tsvf_pkg::OP_LOAD;
                    state_next = ST_EMAG;
                end
            end
            ST_EMAG: begin
                cmd.op     = tsvf_pkg::OP_EMAG;
                state_next = ST_EHI;
            end
            ST_EHI: begin
                cmd.op     = tsvf_pkg::OP_EHI;
                state_next = ST_ELO;
            end
            ST_ELO: begin
                cmd.op     = tsvf_pkg::OP_ELO;
                state_next = ST_IMU;
            end
            ST_IMU: begin
                cmd.op     = tsvf_pkg::OP_IMU;
                state_next = ST_RNG;
            end
            ST_RNG: begin
                cmd.op     = tsvf_pkg::OP_RNG;
                state_next = ST_SATR;
            end
            ST_SATR: begin
                cmd.op     = tsvf_pkg::OP_SATR;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.op     = tsvf_pkg::OP_CMP;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.op     = tsvf_pkg::OP_FIN;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/tsvf_datapath.sv -----
// ----------------------------------------------------------------------------
// tsvf_datapath
// Config registers, sample history, one shared 33x20 multiplier, saturation,
// closest-pair vote and the result register.
// ----------------------------------------------------------------------------
module tsvf_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data,
    input  logic [95:0]       s_tdata,
    output logic [127:0]      m_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tsvf_pkg::dp_cmd_t cmd,
    output tsvf_pkg::dp_sts_t sts
);

    logic [15:0]  period_reg;
    logic [15:0]  rate_reg;
    logic [19:0]  radius_reg;

    logic [31:0]  last_angle_reg;
    logic [31:0]  last_accel_reg;
    logic [31:0]  last_dist_reg;
    logic [31:0]  imu_sum_reg;

    logic [32:0]  da_mag_reg;
    logic         da_neg_reg;
    logic [32:0]  acc_mag_reg;
    logic         acc_neg_reg;
    logic [32:0]  dd_mag_reg;
    logic         dd_neg_reg;
    logic [52:0]  prod_reg;
    logic [15:0]  elo_reg;
    logic [51:0]  ehi_reg;
    logic [31:0]  ve_reg;
    logic [31:0]  vl_reg;
    logic [32:0]  psum_reg;
    logic [127:0] m_tdata_reg;
    logic         m_tvalid_reg;

    logic [31:0]  angle_in;
    logic [31:0]  accel_in;
    logic [31:0]  dist_in;
    logic [32:0]  da;
    logic [32:0]  asum;
    logic [32:0]  dd;
    logic [32:0]  mul_a;
    logic [19:0]  mul_b;
    logic [52:0]  mul_p;
    logic [31:0]  ve_next;
    logic [31:0]  inc;
    logic [31:0]  imu_sum_next;
    logic [31:0]  vl_next;
    logic [32:0]  d_et;
    logic [32:0]  d_el;
    logic [32:0]  d_tl;
    logic [32:0]  psum_next;
    logic [32:0]  psum_adj;

    function automatic logic [32:0] sdiff_abs(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    assign angle_in = s_tdata[31:0];
    assign accel_in = s_tdata[63:32];
    assign dist_in  = s_tdata[95:64];

    assign da   = {angle_in[31], angle_in} - {last_angle_reg[31], last_angle_reg};
    assign asum = {accel_in[31], accel_in} + {last_accel_reg[31], last_accel_reg};
    assign dd   = {dist_in[31], dist_in} - {last_dist_reg[31], last_dist_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            tsvf_pkg::OP_EMAG: begin
                mul_a = da_mag_reg;
                mul_b = {4'b0, rate_reg};
            end
            tsvf_pkg::OP_EHI: begin
                mul_a = {1'b0, prod_reg[47:16]};
                mul_b = radius_reg;
            end
            tsvf_pkg::OP_ELO: begin
                mul_a = {17'b0, elo_reg};
                mul_b = radius_reg;
            end
            tsvf_pkg::OP_IMU: begin
                mul_a = acc_mag_reg;
                mul_b = {4'b0, period_reg};
            end
            tsvf_pkg::OP_RNG: begin
                mul_a = dd_mag_reg;
                mul_b = {4'b0, rate_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {20'b0, mul_a} * {33'b0, mul_b};

    // hi*r + (lo*r >> 16)
    assign ve_next = tsvf_pkg::sat_mag({1'b0, ehi_reg} + {33'b0, prod_reg[35:16]}, da_neg_reg);
    assign inc     = tsvf_pkg::sat_mag({21'b0, prod_reg[48:17]}, acc_neg_reg);
    assign imu_sum_next = tsvf_pkg::sat_s34({{2{imu_sum_reg[31]}}, imu_sum_reg}
                                          + {{2{inc[31]}}, inc});
    assign vl_next = tsvf_pkg::sat_mag({4'b0, prod_reg[48:0]}, dd_neg_reg);

    assign d_et = sdiff_abs(ve_reg, imu_sum_reg);
    assign d_el = sdiff_abs(ve_reg, vl_reg);
    assign d_tl = sdiff_abs(imu_sum_reg, vl_reg);

    always_comb begin
        if ((d_et <= d_el) && (d_et <= d_tl)) begin
            psum_next = {ve_reg[31], ve_reg} + {imu_sum_reg[31], imu_sum_reg};
        end else if ((d_el <= d_et) && (d_el <= d_tl)) begin
            psum_next = {ve_reg[31], ve_reg} + {vl_reg[31], vl_reg};
        end else begin
            psum_next = {imu_sum_reg[31], imu_sum_reg} + {vl_reg[31], vl_reg};
        end
    end

    // halve, truncating toward zero
    assign psum_adj = psum_reg + {32'b0, psum_reg[32]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= tsvf_pkg::SAMPLE_PERIOD_RST;
            rate_reg       <= tsvf_pkg::SAMPLE_RATE_RST;
            radius_reg     <= tsvf_pkg::WHEEL_RADIUS_RST;
            last_angle_reg <= '0;
            last_accel_reg <= '0;
            last_dist_reg  <= '0;
            imu_sum_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tsvf_pkg::CFG_SAMPLE_PERIOD: period_reg <= cfg_data[15:0];
                    tsvf_pkg::CFG_SAMPLE_RATE:   rate_reg   <= cfg_data[15:0];
                    tsvf_pkg::CFG_WHEEL_RADIUS:  radius_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.op == tsvf_pkg::OP_LOAD) begin
                last_angle_reg <= angle_in;
                last_accel_reg <= accel_in;
                last_dist_reg  <= dist_in;
            end
            if (cmd.op == tsvf_pkg::OP_RNG) begin
                imu_sum_reg <= imu_sum_next;
            end
            if (cmd.op == tsvf_pkg::OP_FIN) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            tsvf_pkg::OP_LOAD: begin
                da_mag_reg  <= mag33(da);
                da_neg_reg  <= da[32];
                acc_mag_reg <= mag33(asum);
                acc_neg_reg <= asum[32];
                dd_mag_reg  <= mag33(dd);
                dd_neg_reg  <= dd[32];
            end
            tsvf_pkg::OP_EMAG: begin
                prod_reg <= mul_p;
            end
            tsvf_pkg::OP_EHI: begin
                prod_reg <= mul_p;
                elo_reg  <= prod_reg[15:0];
            end
            tsvf_pkg::OP_ELO: begin
                prod_reg <= mul_p;
                ehi_reg  <= prod_reg[51:0];
            end
            tsvf_pkg::OP_IMU: begin
                prod_reg <= mul_p;
                ve_reg   <= ve_next;
            end
            tsvf_pkg::OP_RNG: begin
                prod_reg <= mul_p;
            end
            tsvf_pkg::OP_SATR: begin
                vl_reg <= vl_next;
            end
            tsvf_pkg::OP_CMP: begin
                psum_reg <= psum_next;
            end
            tsvf_pkg::OP_FIN: begin
                m_tdata_reg <= {psum_adj[32:1], vl_reg, imu_sum_reg, ve_reg};
            end
            default: begin
            end
        endcase
    end

    assign m_tdata      = m_tdata_reg;
    assign m_tvalid     = m_tvalid_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_source_velocity_fusion_core testbench
// Drives sample items through the stream input, writes the rate, period and
// radius registers at each phase start and within phases, and checks every result item against a
// bit-exact model of the encoder, integrated and range speeds and the
// closest-pair vote. Sender and receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;
    localparam logic [31:0] POS_FULL       = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_FULL       = 32'h8000_0000;
    localparam int          ITEMS_PER_PHASE = 350;
    localparam int          ITEMS_PER_SETTING = 88;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] accel;
        logic [31:0] angle;
    } sample_t;

    typedef struct packed {
        logic [31:0] fused;
        logic [31:0] range;
        logic [31:0] imu;
        logic [31:0] encoder;
    } speeds_t;

    class speed_predictor;
        longint  period;
        longint  rate;
        longint  radius;
        longint  prev_angle;
        longint  prev_accel;
        longint  imu_sum;
        longint  prev_dist;
        speeds_t pending_speeds[$];
        int      mismatches;

        function new();
            period     = tsvf_pkg::SAMPLE_PERIOD_RST;
            rate       = tsvf_pkg::SAMPLE_RATE_RST;
            radius     = tsvf_pkg::WHEEL_RADIUS_RST;
            prev_angle = 0;
            prev_accel = 0;
            imu_sum    = 0;
            prev_dist  = 0;
            mismatches = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // (t * m) >> sh, magnitude truncated, saturated
        function longint scale(longint t, longint m, int sh);
            logic        neg;
            logic [63:0] mag;
            logic [63:0] lo;
            logic [63:0] r;
            neg = t < 0;
            mag = neg ? -t : t;
            lo  = mag & ((64'd1 << sh) - 64'd1);
            r   = (mag >> sh) * m + ((lo * m) >> sh);
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return clamp32(neg ? -$signed(r) : $signed(r));
        endfunction

        function longint absdiff(longint a, longint b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] val);
            case (idx)
                tsvf_pkg::CFG_SAMPLE_PERIOD: period = val[15:0];
                tsvf_pkg::CFG_SAMPLE_RATE:   rate   = val[15:0];
                tsvf_pkg::CFG_WHEEL_RADIUS:  radius = val;
                default: ;
            endcase
        endfunction

        function void note_sample(sample_t s);
            longint  ang;
            longint  acc;
            longint  rng;
            longint  ve;
            longint  vt;
            longint  vl;
            longint  vf;
            longint  d_et;
            longint  d_el;
            longint  d_tl;
            speeds_t e;
            ang = $signed(s.angle);
            acc = $signed(s.accel);
            rng = $signed(s.distance);

            ve = scale((ang - prev_angle) * rate, radius, 16);
            prev_angle = ang;

            imu_sum = clamp32(imu_sum + scale(acc + prev_accel, period, 17));
            prev_accel = acc;
            vt = imu_sum;

            vl = clamp32((rng - prev_dist) * rate);
            prev_dist = rng;

            d_et = absdiff(ve, vt);
            d_el = absdiff(ve, vl);
            d_tl = absdiff(vt, vl);
            if (d_et <= d_el && d_et <= d_tl)
                vf = (ve + vt) / 2;
            else if (d_el <= d_et && d_el <= d_tl)
                vf = (ve + vl) / 2;
            else
                vf = (vt + vl) / 2;

            e.encoder = 32'(ve);
            e.imu     = 32'(vt);
            e.range   = 32'(vl);
            e.fused   = 32'(vf);
            pending_speeds.push_back(e);
        endfunction

        function void check_speeds(speeds_t got);
            speeds_t e;
            if (pending_speeds.size() == 0) begin
                $error("result item with none expected: %h", got);
                mismatches++;
                return;
            end
            e = pending_speeds.pop_front();
            if (got.encoder !== e.encoder) begin
                $error("speed_encoder: expected %h, got %h", e.encoder, got.encoder);
                mismatches++;
            end
            if (got.imu !== e.imu) begin
                $error("speed_imu: expected %h, got %h", e.imu, got.imu);
                mismatches++;
            end
            if (got.range !== e.range) begin
                $error("speed_range: expected %h, got %h", e.range, got.range);
                mismatches++;
            end
            if (got.fused !== e.fused) begin
                $error("speed_fused: expected %h, got %h", e.fused, got.fused);
                mismatches++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [19:0]  cfg_data;

    speed_predictor predictor = new();
    int             send_idle_pct;
    int             recv_stall_pct;
    logic [31:0]    last_angle_sent;
    logic [31:0]    last_dist_sent;

    three_source_velocity_fusion_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            predictor.check_speeds(speeds_t'(m_tdata));
        end
    end

    task automatic send_sample(input logic [31:0] angle, input logic [31:0] accel,
                               input logic [31:0] distance);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {distance, accel, angle};
        do @(posedge aclk); while (!s_tready);
        predictor.note_sample({distance, accel, angle});
        last_angle_sent = angle;
        last_dist_sent  = distance;
    endtask

    task automatic send_delta(input int d_angle, input int accel, input int d_dist);
        send_sample(last_angle_sent + 32'(d_angle), 32'(accel), last_dist_sent + 32'(d_dist));
    endtask

    // lowers valid and waits for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predictor.pending_speeds.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        predictor.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_setting(input logic [19:0] period, input logic [19:0] rate,
                                 input logic [19:0] radius);
        write_reg(tsvf_pkg::CFG_SAMPLE_PERIOD, period);
        write_reg(tsvf_pkg::CFG_SAMPLE_RATE, rate);
        write_reg(tsvf_pkg::CFG_WHEEL_RADIUS, radius);
        if ($urandom_range(2) == 0)
            write_reg(CFG_UNUSED_IDX, 20'($urandom));
    endtask

    task automatic pick_setting(input int mode);
        case (mode)
            0: write_setting(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
            1: write_setting(20'h00000, 20'h00000, 20'h00000);
            2: write_setting(20'($urandom_range(1)), 20'd1, 20'h10000);
            3: write_setting(20'($urandom_range(600, 700)), 20'($urandom_range(90, 110)),
                             20'($urandom_range(7000, 9000)));
            default: write_setting(20'($urandom), 20'($urandom), 20'($urandom));
        endcase
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(3))
            0: return POS_FULL;
            1: return NEG_FULL;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int mode;
        mode = $urandom_range(99);
        if (mode < 45)
            send_delta(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                       int'($urandom_range(4000)) - 2000);
        else if (mode < 60)
            send_delta(int'($urandom_range(2097152)) - 1048576,
                       int'($urandom_range(2097152)) - 1048576,
                       int'($urandom_range(2097152)) - 1048576);
        else if (mode < 75)
            send_sample($urandom, $urandom, $urandom);
        else if (mode < 85)
            send_delta(0, int'($urandom_range(200000)) - 100000, 0);
        else
            send_sample(edge_value(), edge_value(), edge_value());
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int first_mode);
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == 0)
                pick_setting(first_mode);
            else if (i % ITEMS_PER_SETTING == 0)
                pick_setting($urandom_range(5));
            else if ($urandom_range(99) == 0)
                drain_results();
            random_item();
        end
    endtask

    initial begin
        #2_000_000;
        $display("three_source_velocity_fusion_core test failed");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = tsvf_pkg::CFG_SAMPLE_PERIOD;
        cfg_data        = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        last_angle_sent = '0;
        last_dist_sent  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first tick against zero history, default registers
        send_sample(32'h0003_2000, 32'd0, 32'h0001_8000);

        // unit scaling with a frozen integral: encoder and range speeds are raw deltas
        write_setting(20'd0, 20'd1, 20'h10000);
        send_delta(10, 0, 20);
        send_delta(10, 0, 5);
        send_delta(-10, 0, 10);
        send_delta(-3, 0, 100);
        send_delta(100, 0, 1);
        send_delta(-100, 0, -3);
        send_delta(0, 0, 0);

        write_reg(tsvf_pkg::CFG_WHEEL_RADIUS, 20'd0);
        send_delta(1000, 0, 7);

        write_setting(20'hFFFF, 20'hFFFF, 20'hFFFFF);
        send_sample(POS_FULL, POS_FULL, POS_FULL);
        send_sample(NEG_FULL, NEG_FULL, NEG_FULL);
        send_sample(NEG_FULL, NEG_FULL, NEG_FULL);
        send_sample(POS_FULL, POS_FULL, POS_FULL);
        send_sample(32'd0, 32'd0, 32'd0);

        write_reg(CFG_UNUSED_IDX, 20'hFFFFF);
        send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
        write_reg(tsvf_pkg::CFG_SAMPLE_RATE, 20'd0);
        send_sample($urandom, $urandom, $urandom);

        run_phase(0, 0, 0);
        run_phase(69, 0, 1);
        run_phase(0, 69, 2);
        run_phase(7, 7, 3);

        drain_results();
        repeat (20) @(posedge aclk);
        if (predictor.mismatches == 0)
            $display("three_source_velocity_fusion_core test passed");
        else
            $display("three_source_velocity_fusion_core test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tsvf_pkg.sv
rtl/core/tsvf_ctrl.sv
rtl/core/tsvf_datapath.sv
rtl/core/three_source_velocity_fusion_core.sv
test/testbench.sv
